// ===== rtl/srvc_pkg.sv =====
// Package for the shadow register bank with vertical-blank commit.
// Holds command and status codes, field widths and the flag struct.
// No dependencies.
package srvc_pkg;

    localparam int CMD_W    = 3;
    localparam int IDX_W    = 4;
    localparam int WORD_W   = 32;
    localparam int LINE_W   = 10;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 4;

    localparam int MAX_RESULTS = 15;
    localparam logic [IDX_W-1:0] HWIN_INDEX = 4'd9;
    localparam logic [IDX_W-1:0] VWIN_INDEX = 4'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 3'd0,
        CMD_BEGIN = 3'd1,
        CMD_END   = 3'd2,
        CMD_VBLANK = 3'd3,
        CMD_BLANK = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_COMMIT    = 2'd0,
        ST_END_ERR   = 2'd1,
        ST_MASK_ERR  = 2'd2,
        ST_RANGE_ERR = 2'd3
    } status_t;

    typedef struct packed {
        logic mask_err;
        logic line_ok;
    } merge_flags_t;

endpackage

// ===== rtl/srvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 14,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/srvc_merge.sv =====
// Merge and check unit: masked merge of a shadow word, mask check and
// commit-window compare of the current line. Depends on srvc_pkg.
module srvc_merge
    import srvc_pkg::*;
(
    input  logic [WORD_W-1:0] old_word,
    input  logic [WORD_W-1:0] write_mask,
    input  logic [WORD_W-1:0] write_value,
    input  logic [LINE_W-1:0] current_line,
    input  logic [LINE_W-1:0] vstart_line,
    output logic [WORD_W-1:0] merged,
    output merge_flags_t      flags
);

    logic [LINE_W-1:0] limit;
    logic [LINE_W-1:0] line_even;

    always_comb
    begin
        merged = (old_word & ~write_mask) | write_value;
        flags.mask_err = (write_value & ~write_mask) != '0;
        limit = (vstart_line < LINE_W'(4)) ? LINE_W'(2) : vstart_line - LINE_W'(2);
        line_even = {current_line[LINE_W-1:1], 1'b0};
        flags.line_ok = line_even < limit;
    end

endmodule

// ===== rtl/shadow_register_vblank_commit.sv =====
// Top level of the shadow register bank with vertical-blank commit.
// Depends on srvc_pkg, srvc_ram and srvc_merge.
//
// Commands arrive on the s_ channel, one item each; results leave on the
// m_ channel, one item per committed word, blank write or error, with
// m_tlast on the final result that a command causes.
// Begin, end, vblank, request blank and unused commands give no result
// when they start no commit; an unmatched end and a failed write each give
// one error result.
// A commit scans the shadow words one index per cycle while they hold no
// pending word, steps through an emit state for each pending word, where it
// waits while the output register is busy, then through the blank step.
// The scan counter and the single RAM read port set this pace.
// s_tready is high only while no command is in work; a finished result
// waits in the output register, so the next command may be taken while the
// last result is still held. When the receiver stalls, the sequencer waits
// before each result until the output register is free.
// After reset the bank reads as all zeros, nothing is pending, no group
// is open and no blank is requested.
module shadow_register_vblank_commit
    import srvc_pkg::*;
#(
    parameter int REG_COUNT = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // reg_index [3:0], write_mask [35:4], write_value [67:36],
    // current_line [77:68], zero fill [79:78]
    input  logic [79:0] s_tdata,
    // cmd [2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_index [3:0], out_value [35:4], zero fill [39:36]
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // status [1:0]
    output logic [1:0]  m_tuser
);

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int SW = $clog2(REG_COUNT + 1);
    localparam logic [SW-1:0] SCAN_END = SW'(REG_COUNT);
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_RESULTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MERGE,
        S_ERR,
        S_SCAN,
        S_EMIT,
        S_BLANK
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [WORD_W-1:0]    mask_reg;
    logic [WORD_W-1:0]    value_reg;
    logic [LINE_W-1:0]    line_reg;
    logic [REG_COUNT-1:0] pending_reg;
    logic [REG_COUNT-1:0] valid_reg;
    logic [7:0]           open_reg;
    logic                 blank_reg;
    logic [LINE_W-1:0]    cfl_reg;
    logic [SW-1:0]        scan_reg;
    logic [CNT_W-1:0]     n_reg;
    status_t              err_reg;
    logic                 m_valid_reg;
    logic [IDX_W-1:0]     m_index_reg;
    logic [WORD_W-1:0]    m_value_reg;
    logic                 m_last_reg;
    status_t              m_status_reg;

    logic                 in_accept;
    logic                 slot_free;
    logic                 m_load;
    cmd_t                 in_cmd;
    logic [IDX_W-1:0]     in_index;
    logic [LINE_W-1:0]    line_sel;
    logic [AW-1:0]        idx_addr;
    logic [AW-1:0]        scan_addr;
    logic                 idx_ok;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    old_word;
    logic [WORD_W-1:0]    scan_word;
    logic [WORD_W-1:0]    merged;
    merge_flags_t         flags;
    logic                 above;

    assign in_accept = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign m_load    = slot_free && ((state_reg == S_ERR) || (state_reg == S_EMIT)
                       || ((state_reg == S_BLANK) && blank_reg && (n_reg != MAX_N)));
    assign in_cmd    = cmd_t'(s_tuser);
    assign in_index  = s_tdata[3:0];
    assign line_sel  = (state_reg == S_IDLE) ? s_tdata[77:68] : line_reg;
    assign idx_addr  = idx_reg[AW-1:0];
    assign scan_addr = scan_reg[AW-1:0];
    assign idx_ok    = {1'b0, idx_reg} < 5'(REG_COUNT);
    assign old_word  = valid_reg[idx_addr] ? ram_rdata : '0;
    assign scan_word = valid_reg[scan_addr] ? ram_rdata : '0;
    assign ram_we    = (state_reg == S_MERGE) && idx_ok && !flags.mask_err;

    always_comb
    begin
        ram_re = 1'b0;
        ram_raddr = scan_addr;
        if (state_reg == S_IDLE)
        begin
            ram_re = in_accept && (in_cmd == CMD_WRITE);
            ram_raddr = in_index[AW-1:0];
        end
        else if (state_reg == S_SCAN)
        begin
            ram_re = (scan_reg != SCAN_END) && (n_reg != MAX_N) && pending_reg[scan_addr];
        end
    end

    always_comb
    begin
        above = 1'b0;
        for (int j = 0; j < REG_COUNT; j++)
        begin
            if ((SW'(j) > scan_reg) && pending_reg[j])
            begin
                above = 1'b1;
            end
        end
    end

    srvc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_addr),
        .wdata (merged),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srvc_merge u_merge (
        .old_word     (old_word),
        .write_mask   (mask_reg),
        .write_value  (value_reg),
        .current_line (line_sel),
        .vstart_line  (cfl_reg),
        .merged       (merged),
        .flags        (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            mask_reg     <= '0;
            value_reg    <= '0;
            line_reg     <= '0;
            pending_reg  <= '0;
            valid_reg    <= '0;
            open_reg     <= '0;
            blank_reg    <= 1'b0;
            cfl_reg      <= '0;
            scan_reg     <= '0;
            n_reg        <= '0;
            err_reg      <= ST_COMMIT;
            m_valid_reg  <= 1'b0;
            m_index_reg  <= '0;
            m_value_reg  <= '0;
            m_last_reg   <= 1'b0;
            m_status_reg <= ST_COMMIT;
        end
        else
        begin
            if (m_valid_reg && m_tready && !m_load)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    scan_reg <= '0;
                    n_reg <= '0;
                    if (in_accept)
                    begin
                        idx_reg   <= (in_cmd == CMD_END) ? '0 : in_index;
                        mask_reg  <= s_tdata[35:4];
                        value_reg <= s_tdata[67:36];
                        line_reg  <= s_tdata[77:68];
                        case (in_cmd)
                            CMD_WRITE:
                            begin
                                state_reg <= S_MERGE;
                            end
                            CMD_BEGIN:
                            begin
                                if (open_reg != 8'd255)
                                begin
                                    open_reg <= open_reg + 8'd1;
                                end
                            end
                            CMD_END:
                            begin
                                if (open_reg == 8'd0)
                                begin
                                    err_reg <= ST_END_ERR;
                                    state_reg <= S_ERR;
                                end
                                else
                                begin
                                    open_reg <= open_reg - 8'd1;
                                    if ((open_reg == 8'd1) && flags.line_ok)
                                    begin
                                        state_reg <= S_SCAN;
                                    end
                                end
                            end
                            CMD_VBLANK:
                            begin
                                if (open_reg == 8'd0)
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            CMD_BLANK:
                            begin
                                blank_reg <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_MERGE:
                begin
                    if (!idx_ok)
                    begin
                        err_reg <= ST_RANGE_ERR;
                        state_reg <= S_ERR;
                    end
                    else if (flags.mask_err)
                    begin
                        err_reg <= ST_MASK_ERR;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        pending_reg[idx_addr] <= 1'b1;
                        valid_reg[idx_addr] <= 1'b1;
                        if ((open_reg == 8'd0) && flags.line_ok)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_ERR:
                begin
                    if (slot_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_index_reg  <= idx_reg;
                        m_value_reg  <= '0;
                        m_last_reg   <= 1'b1;
                        m_status_reg <= err_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if ((scan_reg == SCAN_END) || (n_reg == MAX_N))
                    begin
                        state_reg <= S_BLANK;
                    end
                    else if (pending_reg[scan_addr])
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + SW'(1);
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_index_reg  <= IDX_W'(scan_addr);
                        m_value_reg  <= scan_word;
                        m_last_reg   <= (n_reg == MAX_N - CNT_W'(1)) || (!above && !blank_reg);
                        m_status_reg <= ST_COMMIT;
                        pending_reg[scan_addr] <= 1'b0;
                        if (IDX_W'(scan_addr) == VWIN_INDEX)
                        begin
                            cfl_reg <= scan_word[25:16];
                        end
                        n_reg     <= n_reg + CNT_W'(1);
                        scan_reg  <= scan_reg + SW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_BLANK:
                begin
                    if (!blank_reg || (n_reg == MAX_N))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_index_reg  <= HWIN_INDEX;
                        m_value_reg  <= '0;
                        m_last_reg   <= 1'b1;
                        m_status_reg <= ST_COMMIT;
                        blank_reg    <= 1'b0;
                        if (HWIN_INDEX == VWIN_INDEX)
                        begin
                            cfl_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_value_reg, m_index_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ===== rtl/srvc_checker.sv =====
// Port-level checker for the shadow register bank, bound to the top level.
// Depends on srvc_pkg and shadow_register_vblank_commit.
module srvc_checker
    import srvc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("Stalled result item changed.");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_COMMIT) |-> m_tlast && (m_tdata[35:4] == 32'd0))
        else $error("Error item is not a single zero-valued last item.");

    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_END_ERR) |-> (m_tdata[3:0] == 4'd0))
        else $error("Unmatched end reported a nonzero index.");

    a_begin_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ((s_tuser == CMD_BEGIN) || (s_tuser == CMD_BLANK))
            |=> s_tready)
        else $error("Begin or blank request did not finish in one cycle.");

endmodule

bind shadow_register_vblank_commit srvc_checker u_srvc_checker (.*);
